// ===== sv/lpbd_pkg.sv =====
`timescale 1ns / 1ps
package lpbd_pkg;

  // Default sizes of the directory.
  localparam int NumFramesDef = 16;
  localparam int PageBitsDef  = 24;

  // Request kinds.
  localparam logic [2:0] KIND_FIX     = 3'd0;
  localparam logic [2:0] KIND_FIX_NEW = 3'd1;
  localparam logic [2:0] KIND_MARK    = 3'd2;
  localparam logic [2:0] KIND_UNFIX   = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  // Flash operation codes.
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WB      = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_WB,
    S_PLACE,
    S_MARK,
    S_FCOUNT,
    S_FEMIT,
    S_ONE
  } lpbd_state_e;

  // One result as shown on the output ports.
  typedef struct packed {
    logic [5:0]  frame;
    logic        hit;
    logic [1:0]  op;
    logic [23:0] page;
    logic        last;
  } lpbd_result_t;

endpackage

// ===== sv/lpbd_page_ram.sv =====
`timescale 1ns / 1ps
module lpbd_page_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lru_page_buffer_directory.sv =====
`timescale 1ns / 1ps
// A fix, fix new or unfix walks all frames through the single read port of the page memory
// before it resolves; a fix or fix new miss adds a placement step, a dirty victim a write-back
// step before it. A flush walks the frames once to find dirty ones and, if any, once more to
// emit their write-backs; mark dirty and unknown kinds do not walk the frames. Requests are
// taken only while busy is low. Results are strobed for one cycle, the receiver cannot stall
// them; reset (rst_ni low, async) clears the control state, frame table and counters.
module lru_page_buffer_directory #(
  parameter int NUM_FRAMES = lpbd_pkg::NumFramesDef,
  parameter int PAGE_BITS  = lpbd_pkg::PageBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [23:0] page_i,
  input  logic [5:0]  frame_i,
  output logic        valid_o,
  output logic [5:0]  frame_out_o,
  output logic        hit_o,
  output logic [1:0]  flash_op_o,
  output logic [23:0] flash_page_o,
  output logic        last_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] access_count_o,
  output logic [31:0] read_count_o,
  output logic [31:0] write_count_o
);
  import lpbd_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES);
  localparam logic [FW:0] CntLast = (FW + 1)'(NUM_FRAMES);
  localparam logic [6:0]  NumFr7  = 7'(NUM_FRAMES);

  function automatic logic [5:0] f6(input logic [FW-1:0] x);
    logic [FW+5:0] t;
    t = {6'd0, x};
    return t[5:0];
  endfunction

  function automatic logic [23:0] p24(input logic [PAGE_BITS-1:0] x);
    logic [PAGE_BITS+23:0] t;
    t = {24'd0, x};
    return t[23:0];
  endfunction

  lpbd_state_e state_q, state_d;

  logic [2:0]           kind_q;
  logic [PAGE_BITS-1:0] pg_q, pg_in, rdata;
  logic [PAGE_BITS+23:0] pg_ext;
  logic [5:0]           fr_q;
  logic [FW:0]          cnt_q, cnt_m1;
  logic [FW-1:0]        ev_idx;
  logic                 found_q, free_found_q, any_q;
  logic [FW-1:0]        hitf_q, free_q, vict_q, tgt_q, lastd_q;
  logic [FW-1:0]        best_q;
  logic [NUM_FRAMES-1:0] valid_q, dirty_q;
  logic [FW-1:0]        rank_q [NUM_FRAMES];
  logic [31:0]          hits_q, acc_q, reads_q, writes_q;

  logic                 ram_we;
  logic [FW-1:0]        ram_raddr;
  logic                 touch_en;
  logic [FW-1:0]        touch_f;
  logic [FW:0]          touch_old;
  logic                 emit;
  lpbd_result_t         emit_res, res_q;
  logic                 res_valid_q;
  logic                 mark_ok, victim_dirty;

  assign pg_ext = {{PAGE_BITS{1'b0}}, page_i};
  assign pg_in  = pg_ext[PAGE_BITS-1:0];
  assign cnt_m1 = cnt_q - 1'b1;
  assign ev_idx = cnt_m1[FW-1:0];
  assign mark_ok = ({1'b0, fr_q} < NumFr7) && valid_q[fr_q[FW-1:0]];
  assign victim_dirty = !free_found_q && dirty_q[vict_q];
  assign busy = (state_q != S_IDLE);

  lpbd_page_ram #(
    .DEPTH(NUM_FRAMES),
    .AW   (FW),
    .DW   (PAGE_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tgt_q),
    .wdata_i(pg_q),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_i)
            KIND_FIX, KIND_FIX_NEW, KIND_UNFIX: state_d = S_SCAN;
            KIND_MARK:  state_d = S_MARK;
            KIND_FLUSH: state_d = S_FCOUNT;
            default:    state_d = S_ONE;
          endcase
        end
      end
      S_SCAN: if (cnt_q == CntLast) state_d = S_RESOLVE;
      S_RESOLVE: begin
        if (kind_q == KIND_UNFIX || found_q) state_d = S_IDLE;
        else if (victim_dirty) state_d = S_WB;
        else state_d = S_PLACE;
      end
      S_WB:    state_d = S_PLACE;
      S_FCOUNT: if (cnt_q == CntLast) state_d = any_q ? S_FEMIT : S_IDLE;
      S_FEMIT:  if (cnt_q == CntLast) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory control, recency update and results.
  always_comb begin
    ram_we    = 1'b0;
    ram_raddr = cnt_q[FW-1:0];
    touch_en  = 1'b0;
    touch_f   = tgt_q;
    emit      = 1'b0;
    emit_res  = '0;
    emit_res.last = 1'b1;
    case (state_q)
      S_IDLE: ram_raddr = frame_i[FW-1:0];
      S_RESOLVE: begin
        ram_raddr = vict_q;
        if (kind_q == KIND_UNFIX) begin
          emit = 1'b1;
          emit_res.frame = found_q ? f6(hitf_q) : 6'd0;
          emit_res.op    = OP_RELEASE;
          emit_res.page  = p24(pg_q);
        end else if (found_q) begin
          emit = 1'b1;
          touch_en = 1'b1;
          touch_f  = hitf_q;
          emit_res.frame = f6(hitf_q);
          emit_res.hit   = 1'b1;
          emit_res.page  = p24(pg_q);
        end
      end
      S_WB: begin
        emit = 1'b1;
        emit_res.frame = f6(vict_q);
        emit_res.op    = OP_WB;
        emit_res.page  = p24(rdata);
        emit_res.last  = 1'b0;
      end
      S_PLACE: begin
        ram_we   = 1'b1;
        touch_en = 1'b1;
        emit     = 1'b1;
        emit_res.frame = f6(tgt_q);
        emit_res.op    = (kind_q == KIND_FIX) ? OP_READ : OP_NONE;
        emit_res.page  = p24(pg_q);
      end
      S_MARK: begin
        emit = 1'b1;
        emit_res.frame = fr_q;
        emit_res.page  = mark_ok ? p24(rdata) : 24'd0;
      end
      S_FCOUNT: emit = (cnt_q == CntLast) && !any_q;
      S_FEMIT: begin
        if (cnt_q != '0 && valid_q[ev_idx] && dirty_q[ev_idx]) begin
          emit = 1'b1;
          emit_res.frame = f6(ev_idx);
          emit_res.op    = OP_WB;
          emit_res.page  = p24(rdata);
          emit_res.last  = (ev_idx == lastd_q);
        end
      end
      S_ONE: emit = 1'b1;
      default: ;
    endcase
  end

  assign touch_old = valid_q[touch_f] ? {1'b0, rank_q[touch_f]} : CntLast;

  // Control state, frame table and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      valid_q      <= '0;
      dirty_q      <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) rank_q[i] <= '0;
      hits_q       <= '0;
      acc_q        <= '0;
      reads_q      <= '0;
      writes_q     <= '0;
      res_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      any_q        <= 1'b0;
      kind_q       <= '0;
      pg_q         <= '0;
      fr_q         <= '0;
      best_q       <= '0;
      vict_q       <= '0;
      hitf_q       <= '0;
      free_q       <= '0;
      tgt_q        <= '0;
      lastd_q      <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;

      // Recency update: frames more recent than the touched one age by one.
      if (touch_en) begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (FW'(i) != touch_f && valid_q[i] && {1'b0, rank_q[i]} < touch_old) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        rank_q[touch_f] <= '0;
      end

      case (state_q)
        S_IDLE: begin
          cnt_q        <= '0;
          found_q      <= 1'b0;
          free_found_q <= 1'b0;
          any_q        <= 1'b0;
          best_q       <= '0;
          vict_q       <= '0;
          kind_q       <= kind_i;
          pg_q         <= pg_in;
          fr_q         <= frame_i;
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q != '0) begin
            if (!found_q && valid_q[ev_idx] && rdata == pg_q) begin
              found_q <= 1'b1;
              hitf_q  <= ev_idx;
            end
            if (!free_found_q && !valid_q[ev_idx]) begin
              free_found_q <= 1'b1;
              free_q       <= ev_idx;
            end
            if (rank_q[ev_idx] >= best_q) begin
              best_q <= rank_q[ev_idx];
              vict_q <= ev_idx;
            end
          end
        end
        S_RESOLVE: begin
          tgt_q <= free_found_q ? free_q : vict_q;
          if (kind_q == KIND_UNFIX) begin
            if (found_q) dirty_q[hitf_q] <= 1'b0;
          end else begin
            if (kind_q == KIND_FIX) begin
              acc_q <= acc_q + 1'b1;
              if (found_q) hits_q <= hits_q + 1'b1;
              else reads_q <= reads_q + 1'b1;
            end
            if (!found_q && victim_dirty) writes_q <= writes_q + 1'b1;
          end
        end
        S_PLACE: begin
          valid_q[tgt_q] <= 1'b1;
          dirty_q[tgt_q] <= 1'b0;
        end
        S_MARK: if (mark_ok) dirty_q[fr_q[FW-1:0]] <= 1'b1;
        S_FCOUNT: begin
          if (cnt_q == CntLast) begin
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            if (valid_q[cnt_q[FW-1:0]] && dirty_q[cnt_q[FW-1:0]]) begin
              any_q    <= 1'b1;
              lastd_q  <= cnt_q[FW-1:0];
              writes_q <= writes_q + 1'b1;
            end
          end
        end
        S_FEMIT: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (emit) res_q <= emit_res;
  end

  assign valid_o        = res_valid_q;
  assign frame_out_o    = res_q.frame;
  assign hit_o          = res_q.hit;
  assign flash_op_o     = res_q.op;
  assign flash_page_o   = res_q.page;
  assign last_o         = res_q.last;
  assign hit_count_o    = hits_q;
  assign access_count_o = acc_q;
  assign read_count_o   = reads_q;
  assign write_count_o  = writes_q;

endmodule

// ===== bench/lru_page_buffer_directory_tb.sv =====
`timescale 1ns / 1ps
module lru_page_buffer_directory_tb;
  import lpbd_pkg::*;

  localparam int NumFrames = 16;

  typedef struct {
    logic [5:0]  frame;
    logic        hit;
    logic [1:0]  op;
    logic [23:0] page;
    logic        last;
    logic [31:0] hits;
    logic [31:0] accesses;
    logic [31:0] reads;
    logic [31:0] writes;
  } dir_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  kind_i;
  logic [23:0] page_i;
  logic [5:0]  frame_i;
  logic        valid_o;
  logic [5:0]  frame_out_o;
  logic        hit_o;
  logic [1:0]  flash_op_o;
  logic [23:0] flash_page_o;
  logic        last_o;
  logic [31:0] hit_count_o;
  logic [31:0] access_count_o;
  logic [31:0] read_count_o;
  logic [31:0] write_count_o;

  lru_page_buffer_directory dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kind_i(kind_i), .page_i(page_i), .frame_i(frame_i),
    .valid_o(valid_o), .frame_out_o(frame_out_o), .hit_o(hit_o),
    .flash_op_o(flash_op_o), .flash_page_o(flash_page_o), .last_o(last_o),
    .hit_count_o(hit_count_o), .access_count_o(access_count_o),
    .read_count_o(read_count_o), .write_count_o(write_count_o)
  );

  // Shadow copy of the directory.
  logic        shadow_valid [NumFrames];
  logic [23:0] shadow_page  [NumFrames];
  logic        shadow_dirty [NumFrames];
  int unsigned shadow_rank  [NumFrames];
  logic [31:0] cnt_hits, cnt_accesses, cnt_reads, cnt_writes;

  dir_result_t pending_results[$];
  dir_result_t step_results[$];
  int errors;
  int idle_pct;
  int n_requests;
  int n_checked;
  int n_evict_wb;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void add_result(logic [5:0] fr, logic ht, logic [1:0] op,
                                     logic [23:0] pg);
    dir_result_t r;
    r.frame = fr;
    r.hit = ht;
    r.op = op;
    r.page = pg;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic int find_page(logic [23:0] pg);
    for (int i = 0; i < NumFrames; i++) begin
      if (shadow_valid[i] && shadow_page[i] == pg) return i;
    end
    return -1;
  endfunction

  // Make a frame the most recent, aging the ones that were more recent.
  function automatic void make_recent(int f);
    int unsigned old_rank;
    old_rank = shadow_valid[f] ? shadow_rank[f] : NumFrames;
    for (int i = 0; i < NumFrames; i++) begin
      if (i != f && shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
    end
    shadow_rank[f] = 0;
  endfunction

  // Pick the lowest free frame, or evict the least recent one.
  function automatic int claim_frame(logic [23:0] pg);
    int f;
    int unsigned best;
    f = -1;
    best = 0;
    for (int i = 0; i < NumFrames; i++) begin
      if (f < 0 && !shadow_valid[i]) f = i;
    end
    if (f < 0) begin
      f = 0;
      for (int i = 0; i < NumFrames; i++) begin
        if (shadow_rank[i] >= best) begin
          best = shadow_rank[i];
          f = i;
        end
      end
      if (shadow_dirty[f]) begin
        cnt_writes++;
        n_evict_wb++;
        add_result(f[5:0], 1'b0, OP_WB, shadow_page[f]);
      end
    end
    make_recent(f);
    shadow_valid[f] = 1'b1;
    shadow_page[f] = pg;
    shadow_dirty[f] = 1'b0;
    return f;
  endfunction

  // Work out the results of one request and queue them.
  function automatic void predict_request(logic [2:0] kd, logic [23:0] pg,
                                          logic [5:0] fr);
    int f;
    step_results.delete();
    case (kd)
      KIND_FIX: begin
        cnt_accesses++;
        f = find_page(pg);
        if (f >= 0) begin
          cnt_hits++;
          make_recent(f);
          add_result(f[5:0], 1'b1, OP_NONE, pg);
        end else begin
          f = claim_frame(pg);
          cnt_reads++;
          add_result(f[5:0], 1'b0, OP_READ, pg);
        end
      end
      KIND_FIX_NEW: begin
        f = find_page(pg);
        if (f >= 0) begin
          make_recent(f);
          add_result(f[5:0], 1'b1, OP_NONE, pg);
        end else begin
          f = claim_frame(pg);
          add_result(f[5:0], 1'b0, OP_NONE, pg);
        end
      end
      KIND_MARK: begin
        if (fr < NumFrames && shadow_valid[fr]) begin
          shadow_dirty[fr] = 1'b1;
          add_result(fr, 1'b0, OP_NONE, shadow_page[fr]);
        end else begin
          add_result(fr, 1'b0, OP_NONE, '0);
        end
      end
      KIND_UNFIX: begin
        f = find_page(pg);
        if (f >= 0) begin
          shadow_dirty[f] = 1'b0;
          add_result(f[5:0], 1'b0, OP_RELEASE, pg);
        end else begin
          add_result('0, 1'b0, OP_RELEASE, pg);
        end
      end
      KIND_FLUSH: begin
        for (int i = 0; i < NumFrames; i++) begin
          if (shadow_valid[i] && shadow_dirty[i]) begin
            cnt_writes++;
            add_result(i[5:0], 1'b0, OP_WB, shadow_page[i]);
          end
        end
        if (step_results.size() == 0) add_result('0, 1'b0, OP_NONE, '0);
      end
      default: add_result('0, 1'b0, OP_NONE, '0);
    endcase
    foreach (step_results[i]) begin
      step_results[i].last = (i == step_results.size() - 1);
      step_results[i].hits = cnt_hits;
      step_results[i].accesses = cnt_accesses;
      step_results[i].reads = cnt_reads;
      step_results[i].writes = cnt_writes;
      pending_results.push_back(step_results[i]);
    end
  endfunction

  // Send one request; the shadow is updated at the accepting edge.
  task automatic send_request(logic [2:0] kd, logic [23:0] pg, logic [5:0] fr);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1;
    kind_i <= kd;
    page_i <= pg;
    frame_i <= fr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(kd, pg, fr);
    n_requests++;
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Compare each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    dir_result_t e;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result frame %0d op %0d page %h", $time,
                 frame_out_o, flash_op_o, flash_page_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (frame_out_o !== e.frame || hit_o !== e.hit || flash_op_o !== e.op ||
            flash_page_o !== e.page || last_o !== e.last ||
            hit_count_o !== e.hits || access_count_o !== e.accesses ||
            read_count_o !== e.reads || write_count_o !== e.writes) begin
          $display("%0t: expected fr %0d hit %0b op %0d pg %h last %0b cnt %0d/%0d/%0d/%0d",
                   $time, e.frame, e.hit, e.op, e.page, e.last, e.hits, e.accesses,
                   e.reads, e.writes);
          $display("%0t: actual   fr %0d hit %0b op %0d pg %h last %0b cnt %0d/%0d/%0d/%0d",
                   $time, frame_out_o, hit_o, flash_op_o, flash_page_o, last_o,
                   hit_count_o, access_count_o, read_count_o, write_count_o);
          errors++;
        end
      end
    end
  end

  // Empty directory: flush, mark and unfix with nothing buffered, odd kinds.
  task automatic test_empty_directory();
    send_request(KIND_FLUSH, '0, '0);
    send_request(KIND_MARK, '0, 6'd3);
    send_request(KIND_MARK, '0, 6'd63);
    send_request(KIND_UNFIX, 24'hFFFFFF, '0);
    send_request(3'd5, 24'hABCDEF, 6'd7);
    send_request(3'd7, '0, '0);
  endtask

  // Fill all frames, hit, mark dirty, evict a dirty victim and flush.
  task automatic test_fill_and_evict();
    for (int i = 0; i < NumFrames; i++)
      send_request(i[0] ? KIND_FIX_NEW : KIND_FIX, 24'(24'h000100 + i), '0);
    send_request(KIND_FIX, 24'h000100, '0);
    send_request(KIND_FIX_NEW, 24'h000105, '0);
    send_request(KIND_MARK, '0, 6'd1);
    send_request(KIND_MARK, '0, 6'd15);
    send_request(KIND_MARK, '0, 6'd16);
    send_request(KIND_FLUSH, '0, '0);
    send_request(KIND_FIX, 24'hFFFFFF, '0);
    send_request(KIND_FIX_NEW, 24'h000000, '0);
    send_request(KIND_UNFIX, 24'h00010F, '0);
    send_request(KIND_FLUSH, '0, '0);
  endtask

  // Random traffic over a small page pool so hits and evictions are common.
  task automatic test_random_traffic(int count);
    logic [2:0]  kd;
    logic [23:0] pg;
    logic [5:0]  fr;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: kd = KIND_FIX;
        7, 8: kd = KIND_FIX_NEW;
        9, 10, 11, 12, 13: kd = KIND_MARK;
        14, 15: kd = KIND_UNFIX;
        16, 17: kd = KIND_FLUSH;
        default: kd = 3'($urandom_range(7));
      endcase
      if ($urandom_range(9) == 0) pg = 24'($urandom);
      else pg = 24'($urandom_range(23)) ^ {$urandom_range(1) ? 4'hF : 4'h0, 20'h0};
      fr = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(NumFrames - 1));
      send_request(kd, pg, fr);
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    n_requests = 0;
    n_checked = 0;
    n_evict_wb = 0;
    cnt_hits = '0;
    cnt_accesses = '0;
    cnt_reads = '0;
    cnt_writes = '0;
    for (int i = 0; i < NumFrames; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_page[i] = '0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = '0;
    page_i = '0;
    frame_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_directory();
    test_fill_and_evict();
    idle_pct = 17;
    test_random_traffic(60);
    idle_pct = 71;
    test_random_traffic(60);
    idle_pct = 0;
    test_random_traffic(70);
    wait_drained();

    $display("Sent %0d requests, checked %0d results, %0d dirty evictions.",
             n_requests, n_checked, n_evict_wb);
    $display("Final counters: hits %0d, fixes %0d, reads %0d, write-backs %0d.",
             cnt_hits, cnt_accesses, cnt_reads, cnt_writes);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[lru_page_buffer_directory] OK");
    end else begin
      $display("[lru_page_buffer_directory] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[lru_page_buffer_directory] ERROR");
    $finish;
  end

endmodule
